@@ hdl/gbce_pkg.sv @@
package gbce_pkg;

  // default store depth in bytes
  localparam int BUF_DEPTH_DEF = 1024;

  // width of every count and position field on the ports
  localparam int FIELD_W = 11;

  // item modes
  localparam logic [1:0] MODE_LEFT   = 2'd0;
  localparam logic [1:0] MODE_RIGHT  = 2'd1;
  localparam logic [1:0] MODE_INSERT = 2'd2;

  // result status codes
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_DROPPED = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FIELD_W-1:0] move_count;
    logic [7:0]         char_in;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] cursor_at;
    logic [FIELD_W-1:0] text_len;
    logic [FIELD_W-1:0] gap_end_pos;
    logic               status;
  } out_item_t;

endpackage

@@ hdl/gap_buffer_cursor_engine_top.sv @@
// Gap-buffer text store with the gap always at the cursor. Each input item moves the
// cursor left or right by move_count (clamped at the ends of the text) or inserts one
// byte at the cursor; each item yields exactly one result with the new cursor, text
// length, physical end of the gap and a status bit (1 = insert dropped, store full).
// The text lives in a single BUF_DEPTH x 8 synchronous RAM with one read and one write
// port. A move of n positions copies the n bytes across the gap one byte per cycle
// through that RAM, passing S_MOVE and S_DRAIN before S_DONE registers the result;
// an insert, a move of zero distance and the unused mode go straight to S_DONE. The
// next item is taken only back in S_IDLE, once the result is registered. It is
// accepted while the previous result is still waiting on the output register; only
// a second result that finds it still stalled holds the engine in S_DONE.
// Contents of the RAM are not cleared after reset; the text starts empty, so no
// unwritten byte is ever reported.
module gap_buffer_cursor_engine_top #(
  parameter int BUF_DEPTH = gbce_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbce_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gbce_pkg::out_item_t out_item
);

  localparam int PTR_W = $clog2(BUF_DEPTH + 1);
  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int EW    = (PTR_W > gbce_pkg::FIELD_W) ? PTR_W : gbce_pkg::FIELD_W;
  localparam int FW    = gbce_pkg::FIELD_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOVE  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [PTR_W-1:0] gb_r, gb_nxt;
  logic [PTR_W-1:0] gf_r, gf_nxt;
  logic [PTR_W-1:0] tc_r, tc_nxt;
  logic [PTR_W-1:0] left_r, left_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic             dir_left_r, dir_left_nxt;
  logic             stat_r, stat_nxt;
  logic             pipe_vld_r, pipe_vld_nxt;
  logic [AW-1:0]    pipe_waddr_r;
  logic [7:0]       rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  gbce_pkg::out_item_t out_item_r;

  logic [7:0] mem [BUF_DEPTH];

  logic             accept;
  logic             is_move;
  logic             full;
  logic             ins_we;
  logic [PTR_W-1:0] avail;
  logic [EW-1:0]    cnt_e, avail_e, n_e;
  logic [PTR_W-1:0] n_mov;
  logic [PTR_W-1:0] gb_m1, gf_m1;
  logic             out_free;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [EW-1:0]    gb_e, tc_e, gf_e;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign is_move   = (in_item.mode inside {gbce_pkg::MODE_LEFT, gbce_pkg::MODE_RIGHT});
  assign full      = (gb_r == gf_r);
  assign ins_we    = accept && (in_item.mode == gbce_pkg::MODE_INSERT) && !full;
  assign out_free  = !out_valid_r || !out_stall;

  // move distance: requested count clamped to the room on that side of the cursor
  assign avail   = (in_item.mode == gbce_pkg::MODE_LEFT) ? gb_r : PTR_W'(tc_r - gb_r);
  assign cnt_e   = EW'(in_item.move_count);
  assign avail_e = EW'(avail);
  assign n_e     = (cnt_e < avail_e) ? cnt_e : avail_e;
  assign n_mov   = n_e[PTR_W-1:0];
  assign gb_m1   = PTR_W'(gb_r - 1'b1);
  assign gf_m1   = PTR_W'(gf_r - 1'b1);

  // control and gap bookkeeping
  always_comb begin
    state_nxt     = state_r;
    gb_nxt        = gb_r;
    gf_nxt        = gf_r;
    tc_nxt        = tc_r;
    left_nxt      = left_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    dir_left_nxt  = dir_left_r;
    stat_nxt      = stat_r;
    pipe_vld_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          stat_nxt  = gbce_pkg::STAT_OK;
          state_nxt = S_DONE;
          if (is_move) begin
            dir_left_nxt = (in_item.mode == gbce_pkg::MODE_LEFT);
            left_nxt     = n_mov;
            if (in_item.mode == gbce_pkg::MODE_LEFT) begin
              rd_ptr_nxt = gb_m1[AW-1:0];
              wr_ptr_nxt = gf_m1[AW-1:0];
              gb_nxt     = PTR_W'(gb_r - n_mov);
              gf_nxt     = PTR_W'(gf_r - n_mov);
            end else begin
              rd_ptr_nxt = gf_r[AW-1:0];
              wr_ptr_nxt = gb_r[AW-1:0];
              gb_nxt     = PTR_W'(gb_r + n_mov);
              gf_nxt     = PTR_W'(gf_r + n_mov);
            end
            if (n_mov != '0) begin
              state_nxt = S_MOVE;
            end
          end else if (in_item.mode == gbce_pkg::MODE_INSERT) begin
            if (full) begin
              stat_nxt = gbce_pkg::STAT_DROPPED;
            end else begin
              gb_nxt = PTR_W'(gb_r + 1'b1);
              tc_nxt = PTR_W'(tc_r + 1'b1);
            end
          end
        end
      end
      S_MOVE: begin
        // one byte read per cycle, written back in the next cycle
        pipe_vld_nxt = 1'b1;
        left_nxt     = PTR_W'(left_r - 1'b1);
        if (dir_left_r) begin
          rd_ptr_nxt = AW'(rd_ptr_r - 1'b1);
          wr_ptr_nxt = AW'(wr_ptr_r - 1'b1);
        end else begin
          rd_ptr_nxt = AW'(rd_ptr_r + 1'b1);
          wr_ptr_nxt = AW'(wr_ptr_r + 1'b1);
        end
        if (left_r == PTR_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gb_r        <= '0;
      gf_r        <= PTR_W'(BUF_DEPTH);
      tc_r        <= '0;
      left_r      <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gb_r        <= gb_nxt;
      gf_r        <= gf_nxt;
      tc_r        <= tc_nxt;
      left_r      <= left_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    dir_left_r   <= dir_left_nxt;
    stat_r       <= stat_nxt;
    pipe_waddr_r <= wr_ptr_r;
  end

  // single write port shared by copy write-back and insert
  assign mem_we    = pipe_vld_r || ins_we;
  assign mem_waddr = pipe_vld_r ? pipe_waddr_r : gb_r[AW-1:0];
  assign mem_wdata = pipe_vld_r ? rd_data_r : in_item.char_in;

  // text store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  // result register, low field bits of the gap state
  assign gb_e = EW'(gb_r);
  assign tc_e = EW'(tc_r);
  assign gf_e = EW'(gf_r);

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_item_r.cursor_at   <= gb_e[FW-1:0];
      out_item_r.text_len    <= tc_e[FW-1:0];
      out_item_r.gap_end_pos <= gf_e[FW-1:0];
      out_item_r.status      <= stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hdl/gbce_checker.sv @@
module gbce_checker #(
  parameter int BUF_DEPTH = gbce_pkg::BUF_DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gbce_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input gbce_pkg::out_item_t out_item
);

  localparam int FW = gbce_pkg::FIELD_W;

  logic [FW-1:0] depth_f;
  logic [FW-1:0] len_sum;

  assign depth_f = FW'(BUF_DEPTH);
  assign len_sum = FW'(out_item.text_len + out_item.gap_end_pos - out_item.cursor_at);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or vanished while stalled");

  // text plus gap always fills the store
  a_len_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> len_sum == depth_f)
    else $error("text length and gap do not add up to the store depth");

  // an accepted item always keeps the input busy in the cycle after
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  // a dropped insert leaves no room: cursor meets the gap end
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> out_item.cursor_at == out_item.gap_end_pos)
    else $error("insert dropped although the gap was not empty");

endmodule

bind gap_buffer_cursor_engine_top gbce_checker #(
  .BUF_DEPTH(BUF_DEPTH)
) u_gbce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
